// File: hdl/ctt_pkg.sv
// Shared types, constants and helper functions of the calendar clock tick unit.
package ctt_pkg;

  localparam int unsigned IN_W   = 40;
  localparam int unsigned OUT_W  = 88;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  localparam logic REG_RATE_SELECT = 1'b0;
  localparam logic [2:0] RATE_RESET = 3'd2;

  localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;
  localparam logic [22:0] NS_PER_MS     = 23'd1000000;

  localparam logic [21:0] STEP_256    = 22'd3906250;
  localparam logic [21:0] STEP_512    = 22'd1953125;
  localparam logic [21:0] STEP_1024_A = 22'd976562;
  localparam logic [21:0] STEP_1024_B = 22'd976563;
  localparam logic [21:0] STEP_2048   = 22'd488281;
  localparam logic [21:0] STEP_4096_A = 22'd244140;
  localparam logic [21:0] STEP_4096_B = 22'd244141;
  localparam logic [21:0] STEP_8192   = 22'd122070;

  // 2^64 ns expressed as whole milliseconds plus a nanosecond remainder.
  localparam logic [44:0] MS_AT_WRAP   = 45'd18446744073709;
  localparam logic [19:0] REM_AT_WRAP  = 20'd551616;
  localparam logic [19:0] REM_WRAP_ADD = 20'd448384;

  localparam logic [12:0] CENTURY_RECIP = 13'd5243;
  localparam int unsigned CENTURY_SHIFT = 19;

  localparam logic [5:0]  SECOND_LAST = 6'd59;
  localparam logic [5:0]  MINUTE_LAST = 6'd59;
  localparam logic [4:0]  HOUR_LAST   = 5'd23;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [13:0] YEAR_LAST   = 14'd9999;
  localparam logic [6:0]  YY_LAST     = 7'd99;

  typedef struct packed {
    logic        cmd;
    logic [13:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } item_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [6:0]  yy;
    logic [1:0]  cc;
    logic [44:0] elapsed_ms;
  } cal_t;

  function automatic logic [21:0] step_ns(input logic [2:0] rate, input logic phase);
    case (rate)
      3'd0:    return STEP_256;
      3'd1:    return STEP_512;
      3'd2:    return phase ? STEP_1024_B : STEP_1024_A;
      3'd3:    return STEP_2048;
      3'd4:    return phase ? STEP_4096_B : STEP_4096_A;
      default: return STEP_8192;
    endcase
  endfunction

  function automatic logic [3:0] month_slot(input logic [3:0] m);
    return (m >= 4'd1 && m <= 4'd12) ? 4'(m - 4'd1) : 4'd0;
  endfunction

  function automatic logic is_leap(input logic [6:0] yy, input logic [1:0] cc);
    return ((yy[1:0] == 2'd0) && (yy != 7'd0)) || ((yy == 7'd0) && (cc == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] slot, input logic leap);
    case (slot)
      4'd1:                     return leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  return 5'd30;
      default:                  return 5'd31;
    endcase
  endfunction

  function automatic logic [2:0] month_code(input logic [3:0] slot);
    case (slot)
      4'd1, 4'd2, 4'd10: return 3'd3;
      4'd3, 4'd6:        return 3'd6;
      4'd4:              return 3'd1;
      4'd5:              return 3'd4;
      4'd7:              return 3'd2;
      4'd8, 4'd11:       return 3'd5;
      default:           return 3'd0;
    endcase
  endfunction

  // Octal digits sum to the same residue, since 8 is one more than 7.
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[7:6]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

// File: hdl/ctt_regs.sv
// Configuration register block with its APB-style access port.
module ctt_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctt_pkg::ADDR_W-1:0]  paddr,
  input  logic [ctt_pkg::DATA_W-1:0]  pwdata,
  output logic [ctt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [2:0]                  rate_select
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_select <= ctt_pkg::RATE_RESET;
    end else if (wr_en && (paddr[2] == ctt_pkg::REG_RATE_SELECT)) begin
      rate_select <= pwdata[2:0];
    end
  end

  always_comb begin
    if (paddr[2] == ctt_pkg::REG_RATE_SELECT) begin
      prdata = {29'd0, rate_select};
    end else begin
      prdata = '0;
    end
  end

endmodule

// File: hdl/ctt_split.sv
// Input register and the stage that splits the year to load into centuries.
module ctt_split (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ctt_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output ctt_pkg::item_t out_item,
  output logic [7:0]     out_century
);

  logic           a_valid;
  ctt_pkg::item_t a_item;
  logic           b_take;
  logic [26:0]    product;

  assign b_take   = !out_valid || out_ready;
  assign in_ready = !a_valid || b_take;
  assign product  = 27'(a_item.set_year) * 27'(ctt_pkg::CENTURY_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (b_take) begin
        out_valid <= a_valid;
      end
    end
    if (in_valid && in_ready) begin
      a_item <= in_item;
    end
    if (a_valid && b_take) begin
      out_item    <= a_item;
      out_century <= product[ctt_pkg::CENTURY_SHIFT +: 8];
    end
  end

endmodule

// File: hdl/ctt_calendar.sv
// Time-keeping state: sub-second accumulator, elapsed count and calendar.
module ctt_calendar (
  input  logic           clk,
  input  logic           rst,
  input  logic [2:0]     rate_select,
  input  logic           in_valid,
  output logic           in_ready,
  input  ctt_pkg::item_t in_item,
  input  logic [7:0]     in_century,
  output logic           out_valid,
  input  logic           out_ready,
  output ctt_pkg::cal_t  out_cal
);

  localparam logic [22:0] MS_X2 = 23'(2 * 1000000);
  localparam logic [22:0] MS_X3 = 23'(3 * 1000000);
  localparam logic [22:0] MS_X4 = 23'(4 * 1000000);

  logic        step_phase;
  logic [29:0] subsecond;
  logic [19:0] ms_rem;
  logic [44:0] elapsed_ms;
  logic [5:0]  cur_second;
  logic [5:0]  cur_minute;
  logic [4:0]  cur_hour;
  logic [4:0]  cur_day;
  logic [3:0]  cur_month;
  logic [13:0] cur_year;
  logic [6:0]  cur_yy;
  logic [1:0]  cur_cc;

  logic        step_phase_next;
  logic [29:0] subsecond_next;
  logic [19:0] ms_rem_next;
  logic [44:0] elapsed_ms_next;
  logic [5:0]  cur_second_next;
  logic [5:0]  cur_minute_next;
  logic [4:0]  cur_hour_next;
  logic [4:0]  cur_day_next;
  logic [3:0]  cur_month_next;
  logic [13:0] cur_year_next;
  logic [6:0]  cur_yy_next;
  logic [1:0]  cur_cc_next;

  logic        accept;
  logic [2:0]  rate_eff;
  logic [21:0] delta;
  logic [29:0] sub_sum;
  logic        sec_carry;
  logic        roll_min;
  logic        roll_hour;
  logic        roll_day;
  logic        roll_month;
  logic        roll_year;
  logic [4:0]  days_in_month;
  logic [22:0] rem_sum;
  logic [2:0]  ms_inc;
  logic [22:0] ms_sub;
  logic [19:0] rem_new;
  logic [44:0] ms_sum;
  logic        ns_wrap;
  logic [13:0] hundreds;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign rate_eff = (rate_select > 3'd5) ? 3'd5 : rate_select;
  assign delta    = ctt_pkg::step_ns(rate_eff, step_phase);

  always_comb begin
    sub_sum       = subsecond + 30'(delta);
    sec_carry     = sub_sum >= ctt_pkg::NS_PER_SECOND;
    days_in_month = ctt_pkg::month_len(ctt_pkg::month_slot(cur_month),
                                       ctt_pkg::is_leap(cur_yy, cur_cc));
    roll_min   = sec_carry && (cur_second >= ctt_pkg::SECOND_LAST);
    roll_hour  = roll_min && (cur_minute >= ctt_pkg::MINUTE_LAST);
    roll_day   = roll_hour && (cur_hour >= ctt_pkg::HOUR_LAST);
    roll_month = roll_day && !(cur_day < days_in_month);
    roll_year  = roll_month && (cur_month >= ctt_pkg::MONTH_LAST);

    rem_sum = 23'(ms_rem) + 23'(delta);
    if (rem_sum >= MS_X4) begin
      ms_inc = 3'd4;
      ms_sub = MS_X4;
    end else if (rem_sum >= MS_X3) begin
      ms_inc = 3'd3;
      ms_sub = MS_X3;
    end else if (rem_sum >= MS_X2) begin
      ms_inc = 3'd2;
      ms_sub = MS_X2;
    end else if (rem_sum >= ctt_pkg::NS_PER_MS) begin
      ms_inc = 3'd1;
      ms_sub = ctt_pkg::NS_PER_MS;
    end else begin
      ms_inc = 3'd0;
      ms_sub = 23'd0;
    end
    rem_new = 20'(rem_sum - ms_sub);
    ms_sum  = elapsed_ms + 45'(ms_inc);
    ns_wrap = (ms_sum > ctt_pkg::MS_AT_WRAP) ||
              ((ms_sum == ctt_pkg::MS_AT_WRAP) && (rem_new >= ctt_pkg::REM_AT_WRAP));

    hundreds = 14'({in_century, 6'd0}) + 14'({in_century, 5'd0}) +
               14'({in_century, 2'd0});

    step_phase_next = step_phase;
    subsecond_next  = subsecond;
    ms_rem_next     = ms_rem;
    elapsed_ms_next = elapsed_ms;
    cur_second_next = cur_second;
    cur_minute_next = cur_minute;
    cur_hour_next   = cur_hour;
    cur_day_next    = cur_day;
    cur_month_next  = cur_month;
    cur_year_next   = cur_year;
    cur_yy_next     = cur_yy;
    cur_cc_next     = cur_cc;

    if (in_item.cmd == ctt_pkg::CMD_SET) begin
      cur_second_next = in_item.set_second;
      cur_minute_next = in_item.set_minute;
      cur_hour_next   = in_item.set_hour;
      cur_day_next    = in_item.set_day;
      cur_month_next  = in_item.set_month;
      cur_year_next   = in_item.set_year;
      cur_yy_next     = 7'(in_item.set_year - hundreds);
      cur_cc_next     = in_century[1:0];
      subsecond_next  = 30'd0;
    end else begin
      step_phase_next = !step_phase;
      subsecond_next  = sec_carry ? 30'(sub_sum - ctt_pkg::NS_PER_SECOND) : sub_sum;
      if (!ns_wrap) begin
        ms_rem_next     = rem_new;
        elapsed_ms_next = ms_sum;
      end else if (rem_new >= ctt_pkg::REM_AT_WRAP) begin
        ms_rem_next     = 20'(rem_new - ctt_pkg::REM_AT_WRAP);
        elapsed_ms_next = ms_sum - ctt_pkg::MS_AT_WRAP;
      end else begin
        ms_rem_next     = 20'(rem_new + ctt_pkg::REM_WRAP_ADD);
        elapsed_ms_next = ms_sum - ctt_pkg::MS_AT_WRAP - 45'd1;
      end
      if (sec_carry) begin
        cur_second_next = roll_min ? 6'd0 : 6'(cur_second + 6'd1);
      end
      if (roll_min) begin
        cur_minute_next = roll_hour ? 6'd0 : 6'(cur_minute + 6'd1);
      end
      if (roll_hour) begin
        cur_hour_next = roll_day ? 5'd0 : 5'(cur_hour + 5'd1);
      end
      if (roll_day) begin
        cur_day_next = roll_month ? 5'd1 : 5'(cur_day + 5'd1);
      end
      if (roll_month) begin
        cur_month_next = roll_year ? 4'd1 : 4'(cur_month + 4'd1);
      end
      if (roll_year) begin
        if (cur_year >= ctt_pkg::YEAR_LAST) begin
          cur_year_next = 14'd0;
          cur_yy_next   = 7'd0;
          cur_cc_next   = 2'd0;
        end else begin
          cur_year_next = 14'(cur_year + 14'd1);
          if (cur_yy >= ctt_pkg::YY_LAST) begin
            cur_yy_next = 7'd0;
            cur_cc_next = 2'(cur_cc + 2'd1);
          end else begin
            cur_yy_next = 7'(cur_yy + 7'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      step_phase <= 1'b0;
      subsecond  <= 30'd0;
      ms_rem     <= 20'd0;
      elapsed_ms <= 45'd0;
      cur_second <= 6'd0;
      cur_minute <= 6'd0;
      cur_hour   <= 5'd0;
      cur_day    <= 5'd1;
      cur_month  <= 4'd1;
      cur_year   <= 14'd2000;
      cur_yy     <= 7'd0;
      cur_cc     <= 2'd0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (accept) begin
        step_phase <= step_phase_next;
        subsecond  <= subsecond_next;
        ms_rem     <= ms_rem_next;
        elapsed_ms <= elapsed_ms_next;
        cur_second <= cur_second_next;
        cur_minute <= cur_minute_next;
        cur_hour   <= cur_hour_next;
        cur_day    <= cur_day_next;
        cur_month  <= cur_month_next;
        cur_year   <= cur_year_next;
        cur_yy     <= cur_yy_next;
        cur_cc     <= cur_cc_next;
      end
    end
    if (accept) begin
      out_cal.second     <= cur_second_next;
      out_cal.minute     <= cur_minute_next;
      out_cal.hour       <= cur_hour_next;
      out_cal.day        <= cur_day_next;
      out_cal.month      <= cur_month_next;
      out_cal.year       <= cur_year_next;
      out_cal.yy         <= cur_yy_next;
      out_cal.cc         <= cur_cc_next;
      out_cal.elapsed_ms <= elapsed_ms_next;
    end
  end

endmodule

// File: hdl/ctt_result.sv
// Day-of-week calculation and the result output register.
module ctt_result (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ctt_pkg::cal_t              in_cal,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ctt_pkg::OUT_W-1:0]  out_data
);

  logic [3:0] slot;
  logic       leap;
  logic [4:0] dow_sum;
  logic [2:0] dow;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    slot    = ctt_pkg::month_slot(in_cal.month);
    leap    = ctt_pkg::is_leap(in_cal.yy, in_cal.cc);
    dow_sum = 5'(ctt_pkg::mod7(8'(in_cal.day))) +
              5'(ctt_pkg::month_code(slot)) +
              5'(ctt_pkg::mod7(8'(in_cal.yy) + 8'(in_cal.yy[6:2]))) +
              5'({~in_cal.cc, 1'b0}) +
              (((slot < 4'd2) && leap) ? 5'd6 : 5'd0);
    dow     = ctt_pkg::mod7(8'(dow_sum));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_data <= {in_cal.elapsed_ms, dow, in_cal.year, in_cal.month, in_cal.day,
                   in_cal.hour, in_cal.minute, in_cal.second};
    end
  end

endmodule

// File: hdl/calendar_clock_tick_unit.sv
// Top level of the calendar clock tick unit.
// Each input transaction is either one periodic tick or a set-time command,
// and each produces exactly one result transaction carrying the calendar,
// the day of week and the elapsed milliseconds after that item. The unit
// takes one transaction per clock cycle for as long as results are taken,
// and a result passes in order through an input register, the register
// holding the year split into centuries (one constant multiplication),
// the time-keeping state update and the output register. Back-pressure on
// the result side stalls the stages in order; each stage holds one item.
// The tick rate register should only be written while no transaction is
// in flight.
module calendar_clock_tick_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctt_pkg::ADDR_W-1:0]  paddr,
  input  logic [ctt_pkg::DATA_W-1:0]  pwdata,
  output logic [ctt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // set_second, set_minute, set_hour, set_day, set_month, set_year
  input  logic [ctt_pkg::IN_W-1:0]    s_tdata,
  // cmd
  input  logic                        s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // second, minute, hour, day, month, year, day_of_week, elapsed_ms
  output logic [ctt_pkg::OUT_W-1:0]   m_tdata
);

  logic [2:0]     rate_select;
  ctt_pkg::item_t in_item;
  logic           split_valid;
  logic           split_ready;
  ctt_pkg::item_t split_item;
  logic [7:0]     split_century;
  logic           cal_valid;
  logic           cal_ready;
  ctt_pkg::cal_t  cal;

  always_comb begin
    in_item.cmd        = s_tuser;
    in_item.set_second = s_tdata[5:0];
    in_item.set_minute = s_tdata[11:6];
    in_item.set_hour   = s_tdata[16:12];
    in_item.set_day    = s_tdata[21:17];
    in_item.set_month  = s_tdata[25:22];
    in_item.set_year   = s_tdata[39:26];
  end

  ctt_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .rate_select (rate_select)
  );

  ctt_split u_split (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_item     (in_item),
    .out_valid   (split_valid),
    .out_ready   (split_ready),
    .out_item    (split_item),
    .out_century (split_century)
  );

  ctt_calendar u_calendar (
    .clk         (clk),
    .rst         (rst),
    .rate_select (rate_select),
    .in_valid    (split_valid),
    .in_ready    (split_ready),
    .in_item     (split_item),
    .in_century  (split_century),
    .out_valid   (cal_valid),
    .out_ready   (cal_ready),
    .out_cal     (cal)
  );

  ctt_result u_result (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cal_valid),
    .in_ready  (cal_ready),
    .in_cal    (cal),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

`ifndef SYNTHESIS
  a_dow_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[42:40] != 3'd7))
    else $error("Day of week out of range.");

  a_yy_range: assert property (@(posedge clk) disable iff (rst)
    cal_valid |-> (cal.yy < 7'd100))
    else $error("Year within century out of range.");

  a_year_zero: assert property (@(posedge clk) disable iff (rst)
    (cal_valid && (cal.year == 14'd0)) |-> ((cal.yy == 7'd0) && (cal.cc == 2'd0)))
    else $error("Century split disagrees with year zero.");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("Input stalled although the result side is taking transactions.");
`endif

endmodule
